/* rtl/gum_pkg.sv */
package gum_pkg;

  localparam int PIX_W    = 8;
  localparam int CNT_W    = 11;
  localparam int WF_W     = 17;
  localparam int K_W      = 16;
  localparam int IDX_W    = 3;
  localparam int CFG_W    = 17;
  localparam int HEIGHT_CAP = 1024;

  // arithmetic widths
  localparam int WT_W   = 34;  // tap weight, Q2.32
  localparam int S_W    = 45;  // weighted pixel sum
  localparam int D_W    = 37;  // weight sum
  localparam int NUM_W  = 61;  // numerator
  localparam int DEN_W  = 53;  // denominator
  localparam int S_HALF = 23;
  localparam int D_HALF = 19;

  localparam logic [WF_W-1:0] ONE_Q16 = 17'h10000;

  // register indexes
  localparam logic [IDX_W-1:0] REG_BORDER = 3'd0;
  localparam logic [IDX_W-1:0] REG_WIDTH  = 3'd1;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd2;
  localparam logic [IDX_W-1:0] REG_WVERT  = 3'd3;
  localparam logic [IDX_W-1:0] REG_WHORZ  = 3'd4;
  localparam logic [IDX_W-1:0] REG_SHARPK = 3'd5;

  // border modes
  localparam logic [1:0] BM_ZERO   = 2'd0;
  localparam logic [1:0] BM_MIRROR = 2'd1;
  localparam logic [1:0] BM_RENORM = 2'd2;

  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic up_ok;
    logic dn_ok;
    logic lf_ok;
    logic rt_ok;
    logic fe;
  } bflags_t;

  typedef struct packed {
    win_t    win;
    bflags_t fl;
  } job_t;

  typedef struct packed {
    logic [1:0]       border;
    logic [CNT_W-1:0] width;
    logic [CNT_W-1:0] height;
    logic [WF_W-1:0]  fv;
    logic [WF_W-1:0]  fh;
    logic [K_W-1:0]   k;
  } cfg_t;

  typedef struct packed {
    logic push;
    logic full;
  } qwr_t;

endpackage

/* rtl/gum_in_if.sv */
interface gum_in_if import gum_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             is_padding;
  modport source(output valid, pixel, is_padding, input ready);
  modport sink(input valid, pixel, is_padding, output ready);
endinterface

/* rtl/gum_out_if.sv */
interface gum_out_if import gum_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_pixel;
  logic             frame_end;
  modport source(output valid, out_pixel, frame_end, input ready);
  modport sink(input valid, out_pixel, frame_end, output ready);
endinterface

/* rtl/gum_cfg_if.sv */
interface gum_cfg_if import gum_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [CFG_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* rtl/gum_queue.sv */
module gum_queue import gum_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  qwr_t wr_in,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_job   = mem_r[rp_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_in.push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_in.push) - 2'(pop);
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (wr_in.push) mem_r[wp_r] <= push_job;
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_in.push |-> !full) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid) else $error("queue pop while empty");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
`endif

endmodule

/* rtl/gum_front.sv */
module gum_front import gum_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        pos_clr,
  gum_in_if.sink      in_ch,
  input  logic        q_full,
  output qwr_t        q_wr,
  output job_t        q_job
);

  localparam int AW = $clog2(2 * MAX_WIDTH);

  typedef enum logic {F_IDLE, F_UPD} fstate_t;

  fstate_t          st_r;
  logic [CNT_W-1:0] row_r, col_r;
  logic [PIX_W-1:0] pix_r, top_r, mid_r;
  logic [AW-1:0]    cur_r;
  logic [PIX_W-1:0] line_mem [2 * MAX_WIDTH];
  win_t             win_r, win_nxt;

  logic             accept, skip, emit, col_last, fe;
  logic [AW-1:0]    cur_a, oth_a;
  logic [CNT_W-1:0] y, x;
  bflags_t          fl;

  assign in_ch.ready = (st_r == F_IDLE) && !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign skip        = in_ch.is_padding && (row_r == '0) && (col_r == '0);

  // line store addresses by row parity
  assign cur_a = row_r[0] ? AW'(MAX_WIDTH) + AW'(col_r) : AW'(col_r);
  assign oth_a = row_r[0] ? AW'(col_r) : AW'(MAX_WIDTH) + AW'(col_r);

  // line store: read on accept, write back in the next cycle
  always_ff @(posedge clk) begin
    if (accept && !skip) begin
      top_r <= line_mem[cur_a];
      mid_r <= line_mem[oth_a];
      cur_r <= cur_a;
      pix_r <= in_ch.is_padding ? '0 : in_ch.pixel;
    end
    if (st_r == F_UPD) line_mem[cur_r] <= pix_r;
  end

  // window shift
  always_comb begin
    win_nxt = win_r;
    for (int i = 0; i < 3; i++) begin
      win_nxt[i][0] = win_r[i][1];
      win_nxt[i][1] = win_r[i][2];
    end
    win_nxt[0][2] = top_r;
    win_nxt[1][2] = mid_r;
    win_nxt[2][2] = pix_r;
  end

  // output position and border classification
  assign emit = (row_r >= 11'd2) || ((row_r == 11'd1) && (col_r != '0));
  assign y    = (col_r != '0) ? row_r - 11'd1 : row_r - 11'd2;
  assign x    = (col_r != '0) ? col_r - 11'd1 : cfg.width - 11'd1;
  assign fe   = (y == cfg.height - 11'd1) && (x == cfg.width - 11'd1);
  assign col_last = ({1'b0, col_r} + 12'd1) >= {1'b0, cfg.width};

  always_comb begin
    fl.up_ok = (y != '0);
    fl.dn_ok = ({1'b0, y} + 12'd1) < {1'b0, cfg.height};
    fl.lf_ok = (x != '0);
    fl.rt_ok = ({1'b0, x} + 12'd1) < {1'b0, cfg.width};
    fl.fe    = fe;
  end

  assign q_wr.push = (st_r == F_UPD) && emit;
  assign q_wr.full = q_full;
  assign q_job     = '{win: win_nxt, fl: fl};

  // state, position and window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= F_IDLE;
      row_r <= '0;
      col_r <= '0;
      win_r <= '0;
    end else begin
      unique case (st_r)
        F_IDLE: begin
          if (accept && !skip) st_r <= F_UPD;
        end
        F_UPD: begin
          win_r <= win_nxt;
          st_r  <= F_IDLE;
        end
        default: st_r <= F_IDLE;
      endcase
      // frame position
      if (pos_clr || (st_r == F_UPD && emit && fe)) begin
        row_r <= '0;
        col_r <= '0;
      end else if (st_r == F_UPD) begin
        if (col_last) begin
          col_r <= '0;
          row_r <= row_r + 11'd1;
        end else begin
          col_r <= col_r + 11'd1;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == F_IDLE && !$past(pos_clr)) |-> (col_r < cfg.width || $changed(cfg.width)))
    else $error("column position beyond row width");
`endif

endmodule

/* rtl/gum_back.sv */
module gum_back import gum_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     q_valid,
  input  job_t     q_job,
  output logic     q_pop,
  gum_out_if.source out_ch
);

  typedef enum logic [2:0] {
    B_IDLE, B_TAP, B_FLUSH, B_MUL, B_CMB, B_CHK, B_DIV, B_OUT
  } bstate_t;

  bstate_t            st_r;
  logic               out_valid_r;
  logic [PIX_W-1:0]   opix_r;
  logic               ofe_r;
  logic [1:0]         tr_r, tc_r;
  logic [2:0]         mstep_r, dcnt_r;
  logic               v1_r;

  job_t               job_r;
  logic [WT_W-1:0]    wt_r;
  logic [PIX_W-1:0]   px_r;
  logic               incs_r, incd_r;
  logic [S_W-1:0]     s_r;
  logic [D_W-1:0]     d_r;
  logic [D_W+PIX_W-1:0] cdc_r;
  logic [K_W+S_HALF-1:0] ksl_r, ksh_r;
  logic [WF_W+D_HALF-1:0] denl_r, denh_r;
  logic [NUM_W-1:0]   num_r, rem_r, dsh_r;
  logic [DEN_W-1:0]   den_r;
  logic               neg_r;
  logic [PIX_W-1:0]   q_r;

  logic               rv, rv_opp, cv, cv_opp, incs, incd, slot_free;
  logic [1:0]         msr, msc;
  logic [WF_W-1:0]    fa, fb, km;
  logic [PIX_W-1:0]   px, center;
  logic [NUM_W-1:0]   cd, ks;
  logic [DEN_W-1:0]   den;
  logic [NUM_W+1:0]   lim;

  assign q_pop     = (st_r == B_IDLE) && q_valid;
  assign slot_free = !out_valid_r || out_ch.ready;
  assign center    = job_r.win[1][1];
  assign km        = ONE_Q16 - {1'b0, cfg.k};

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_pixel = opix_r;
  assign out_ch.frame_end = ofe_r;

  // tap selection for the current window position
  always_comb begin
    rv     = (tr_r == 2'd1) || ((tr_r == 2'd0) ? job_r.fl.up_ok : job_r.fl.dn_ok);
    rv_opp = (tr_r == 2'd0) ? job_r.fl.dn_ok : job_r.fl.up_ok;
    cv     = (tc_r == 2'd1) || ((tc_r == 2'd0) ? job_r.fl.lf_ok : job_r.fl.rt_ok);
    cv_opp = (tc_r == 2'd0) ? job_r.fl.rt_ok : job_r.fl.lf_ok;
    msr    = rv ? tr_r : (rv_opp ? 2'd2 - tr_r : 2'd1);
    msc    = cv ? tc_r : (cv_opp ? 2'd2 - tc_r : 2'd1);
    fa     = (tr_r == 2'd1) ? ONE_Q16 : cfg.fv;
    fb     = (tc_r == 2'd1) ? ONE_Q16 : cfg.fh;
    px     = job_r.win[tr_r][tc_r];
    incs   = rv && cv;
    incd   = 1'b1;
    unique case (cfg.border)
      BM_MIRROR: begin
        px   = job_r.win[msr][msc];
        incs = 1'b1;
      end
      BM_RENORM: incd = rv && cv;
      default: ;
    endcase
  end

  // combine partial products
  always_comb begin
    cd  = {cdc_r, 16'b0};
    ks  = NUM_W'(ksl_r) + (NUM_W'(ksh_r) << S_HALF);
    den = DEN_W'(denl_r) + (DEN_W'(denh_r) << D_HALF);
    lim = ((NUM_W+2)'(den_r) << 8) - (NUM_W+2)'(den_r);
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      out_valid_r <= 1'b0;
      tr_r        <= '0;
      tc_r        <= '0;
      mstep_r     <= '0;
      dcnt_r      <= '0;
      v1_r        <= 1'b0;
    end else begin
      out_valid_r <= (st_r == B_OUT && slot_free) || (out_valid_r && !out_ch.ready);
      v1_r <= (st_r == B_TAP);
      unique case (st_r)
        B_IDLE: begin
          if (q_valid) begin
            st_r <= B_TAP;
            tr_r <= '0;
            tc_r <= '0;
          end
        end
        B_TAP: begin
          if (tc_r == 2'd2) begin
            tc_r <= '0;
            tr_r <= tr_r + 2'd1;
            if (tr_r == 2'd2) st_r <= B_FLUSH;
          end else begin
            tc_r <= tc_r + 2'd1;
          end
        end
        B_FLUSH: begin
          st_r    <= B_MUL;
          mstep_r <= '0;
        end
        B_MUL: begin
          mstep_r <= mstep_r + 3'd1;
          if (mstep_r == 3'd4) st_r <= B_CMB;
        end
        B_CMB: st_r <= B_CHK;
        B_CHK: begin
          if (neg_r || (NUM_W+2)'(num_r) > lim) begin
            st_r <= B_OUT;
          end else begin
            st_r   <= B_DIV;
            dcnt_r <= '0;
          end
        end
        B_DIV: begin
          dcnt_r <= dcnt_r + 3'd1;
          if (dcnt_r == 3'd7) st_r <= B_OUT;
        end
        B_OUT: begin
          if (slot_free) begin
            opix_r      <= q_r;
            ofe_r       <= job_r.fl.fe;
            st_r        <= B_IDLE;
          end
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_job;
      s_r   <= '0;
      d_r   <= '0;
    end
    if (st_r == B_TAP) begin
      wt_r   <= WT_W'(fa) * WT_W'(fb);
      px_r   <= px;
      incs_r <= incs;
      incd_r <= incd;
    end
    if (v1_r) begin
      if (incs_r) s_r <= s_r + S_W'(wt_r) * S_W'(px_r);
      if (incd_r) d_r <= d_r + D_W'(wt_r);
    end
    if (st_r == B_MUL) begin
      unique case (mstep_r)
        3'd0:    cdc_r  <= d_r * center;
        3'd1:    ksl_r  <= cfg.k * s_r[S_HALF-1:0];
        3'd2:    ksh_r  <= cfg.k * s_r[S_W-1:S_HALF];
        3'd3:    denl_r <= km * d_r[D_HALF-1:0];
        default: denh_r <= km * d_r[D_W-1:D_HALF];
      endcase
    end
    if (st_r == B_CMB) begin
      neg_r <= ks > cd;
      num_r <= cd - ks;
      den_r <= den;
    end
    if (st_r == B_CHK) begin
      // negative clamps to zero, overflow passes the center, else divide from zero
      q_r   <= (neg_r || (NUM_W+2)'(num_r) <= lim) ? '0 : center;
      rem_r <= num_r;
      dsh_r <= NUM_W'(den_r) << 7;
    end
    if (st_r == B_DIV) begin
      dsh_r <= dsh_r >> 1;
      if (rem_r >= dsh_r) begin
        rem_r <= rem_r - dsh_r;
        q_r   <= {q_r[PIX_W-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[PIX_W-2:0], 1'b0};
      end
    end
  end

`ifndef ASSERT_OFF
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_DIV) |-> (dsh_r != '0)) else $error("divide by zero shift");
  a_out_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_OUT && out_valid_r && !out_ch.ready) |=> (st_r == B_OUT))
    else $error("result overwrote a pending output");
`endif

endmodule

/* rtl/gaussian_unsharp_mask_3x3_unit.sv */
// Streaming 3x3 Gaussian unsharp mask for 8-bit grayscale pixels in raster
// order. Each result lags its input by image_width+1 pixels, so a frame takes
// H*W pixels plus W+1 padding requests to drain; a padding request at frame
// start is dropped. The front end reads the line store when it takes a pixel,
// then does write-back and window shift before it takes the next one, and
// hands window jobs through a 2-entry queue to the back end. The back end
// finishes each job, with the 8-step restoring divider unless the result is
// clamped, before it pops the next, and it sets the sustained rate. The line
// store holds 2*MAX_WIDTH bytes with no reset; entries that were never written
// only feed taps outside the image. Configure only while the block is idle;
// writing image_width or image_height restarts the frame position.
module gaussian_unsharp_mask_3x3_unit import gum_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  gum_in_if.sink     in_ch,
  gum_out_if.source  out_ch,
  gum_cfg_if.sink    cfg_ch
);

  logic [1:0]       border_r;
  logic [CNT_W-1:0] width_r, height_r;
  logic [WF_W-1:0]  fv_r, fh_r;
  logic [K_W-1:0]   k_r;

  cfg_t  cfg;
  logic  cfg_acc, pos_clr, q_full, q_valid, q_pop;
  qwr_t  q_wr;
  job_t  q_job_in, q_head;

  assign cfg_ch.ready = 1'b1;
  assign cfg_acc = cfg_ch.valid && cfg_ch.ready;
  assign pos_clr = cfg_acc && (cfg_ch.index == REG_WIDTH || cfg_ch.index == REG_HEIGHT);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      border_r <= BM_ZERO;
      width_r  <= 11'd512;
      height_r <= 11'd512;
      fv_r     <= 17'd39749;
      fh_r     <= 17'd39749;
      k_r      <= 16'd52429;
    end else if (cfg_acc) begin
      unique case (cfg_ch.index)
        REG_BORDER: border_r <= cfg_ch.data[1:0];
        REG_WIDTH:  width_r  <= cfg_ch.data[CNT_W-1:0];
        REG_HEIGHT: height_r <= cfg_ch.data[CNT_W-1:0];
        REG_WVERT:  fv_r     <= cfg_ch.data[WF_W-1:0];
        REG_WHORZ:  fh_r     <= cfg_ch.data[WF_W-1:0];
        REG_SHARPK: k_r      <= cfg_ch.data[K_W-1:0];
        default: ;
      endcase
    end
  end

  // saturated frame size
  always_comb begin
    cfg.border = border_r;
    cfg.fv     = fv_r;
    cfg.fh     = fh_r;
    cfg.k      = k_r;
    if (width_r == '0) cfg.width = 11'd1;
    else if (32'(width_r) > MAX_WIDTH) cfg.width = CNT_W'(MAX_WIDTH);
    else cfg.width = width_r;
    if (height_r == '0) cfg.height = 11'd1;
    else if (32'(height_r) > HEIGHT_CAP) cfg.height = CNT_W'(HEIGHT_CAP);
    else cfg.height = height_r;
  end

  gum_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .pos_clr (pos_clr),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_wr    (q_wr),
    .q_job   (q_job_in)
  );

  gum_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_in      (q_wr),
    .push_job   (q_job_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (q_head)
  );

  gum_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_job   (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import gum_pkg::*;

  localparam int LINE_MAX    = 1024;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 100;

  typedef struct {
    logic [PIX_W-1:0] pixel;
    logic             pad;
  } pix_req_t;

  typedef struct {
    logic [PIX_W-1:0] out_pixel;
    logic             frame_end;
  } sharp_res_t;

  logic clk;
  logic rst_n;

  gum_in_if  in_bus();
  gum_out_if out_bus();
  gum_cfg_if cfg_bus();

  gaussian_unsharp_mask_3x3_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // pending pixel requests and expected sharpened pixels
  pix_req_t   pixel_q[$];
  sharp_res_t sharp_q[$];
  pix_req_t   next_req;
  sharp_res_t got_res;
  sharp_res_t want_res;

  int          cyc;
  int          errors;
  int          results_seen;
  int          hold_left;
  bit          hold_done;
  bit          calm;
  int          items_sent;

  // shadow of the block configuration and stream state
  logic [1:0]       sh_border;
  logic [CNT_W-1:0] sh_width;
  logic [CNT_W-1:0] sh_height;
  logic [WF_W-1:0]  sh_fv;
  logic [WF_W-1:0]  sh_fh;
  logic [K_W-1:0]   sh_k;
  byte unsigned     rows_mem [0:2*LINE_MAX-1];
  byte unsigned     win [0:2][0:2];
  int unsigned      pos_row;
  int unsigned      pos_col;

  // clock
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // cycle counter and timeout
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  assign calm = (cyc >= 30000) && (cyc < 45000);

  function automatic int unsigned eff_size(input logic [CNT_W-1:0] v);
    int unsigned r;
    r = v;
    if (r < 1) r = 1;
    if (r > LINE_MAX) r = LINE_MAX;
    return r;
  endfunction

  function automatic bit in_range(input int v, input int unsigned n);
    return (v >= 0) && (v < int'(n));
  endfunction

  // weighted blur, unsharp formula and clamp for the window centered at (y, x)
  function automatic logic [PIX_W-1:0] sharpen_at(input int y, input int x,
                                                   input int unsigned w,
                                                   input int unsigned h);
    longint unsigned s, d, wt, cd, ks, num, den, fa, fb;
    int  ra, cb;
    bit  rv, cv;
    byte unsigned center;
    s = 0;
    d = 0;
    center = win[1][1];
    for (int a = -1; a <= 1; a++) begin
      for (int b = -1; b <= 1; b++) begin
        rv = in_range(y + a, h);
        cv = in_range(x + b, w);
        fa = (a == 0) ? 64'd65536 : longint'(sh_fv);
        fb = (b == 0) ? 64'd65536 : longint'(sh_fh);
        wt = fa * fb;
        if (sh_border == BM_RENORM) begin
          if (rv && cv) begin
            s += wt * win[1+a][1+b];
            d += wt;
          end
        end else begin
          d += wt;
          if (sh_border == BM_MIRROR) begin
            ra = rv ? a : (in_range(y - a, h) ? -a : 0);
            cb = cv ? b : (in_range(x - b, w) ? -b : 0);
            s += wt * win[1+ra][1+cb];
          end else if (rv && cv) begin
            s += wt * win[1+a][1+b];
          end
        end
      end
    end
    cd = longint'(center) * d * 64'd65536;
    ks = longint'(sh_k) * s;
    if (ks > cd) return '0;
    num = cd - ks;
    den = d * (64'd65536 - longint'(sh_k));
    if (num > 64'd255 * den) return center;
    return PIX_W'(num / den);
  endfunction

  // advance the stream by one request; returns 1 when a result is due
  function automatic bit sharpen_step(input pix_req_t req, output sharp_res_t res);
    int unsigned w, h, r, c, cur, oth;
    byte unsigned pix, top, mid;
    int y, x;
    w = eff_size(sh_width);
    h = eff_size(sh_height);
    r = pos_row;
    c = pos_col;
    res.out_pixel = '0;
    res.frame_end = 1'b0;
    if (req.pad && r == 0 && c == 0) return 1'b0;
    pix = req.pad ? 8'd0 : req.pixel;
    cur = (r & 1) * LINE_MAX + c;
    oth = ((r + 1) & 1) * LINE_MAX + c;
    top = rows_mem[cur];
    mid = rows_mem[oth];
    rows_mem[cur] = pix;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = pix;
    if (c + 1 >= w) begin
      pos_col = 0;
      pos_row = r + 1;
    end else begin
      pos_col = c + 1;
    end
    if (!(r >= 2 || (r == 1 && c >= 1))) return 1'b0;
    y = (c >= 1) ? int'(r) - 1 : int'(r) - 2;
    x = (c >= 1) ? int'(c) - 1 : int'(w) - 1;
    res.out_pixel = sharpen_at(y, x, w, h);
    res.frame_end = (y == int'(h) - 1) && (x == int'(w) - 1);
    if (res.frame_end) begin
      pos_row = 0;
      pos_col = 0;
    end
    return 1'b1;
  endfunction

  // pixel driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_bus.ready) begin
      if (pixel_q.size() > 0 && (calm || $urandom_range(99) >= 12)) begin
        next_req = pixel_q.pop_front();
        in_bus.valid      <= 1'b1;
        in_bus.pixel      <= next_req.pixel;
        in_bus.is_padding <= next_req.pad;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // result receiver with random stalls and one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      hold_left     <= 0;
      hold_done     <= 1'b0;
    end else if (!hold_done && results_seen >= 300) begin
      hold_done     <= 1'b1;
      hold_left     <= 600;
      out_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= calm || ($urandom_range(99) >= 12);
    end
  end

  // monitor: config shadow, prediction on accepted pixels, result check
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          REG_BORDER: sh_border = cfg_bus.data[1:0];
          REG_WIDTH: begin
            sh_width = cfg_bus.data[CNT_W-1:0];
            pos_row  = 0;
            pos_col  = 0;
          end
          REG_HEIGHT: begin
            sh_height = cfg_bus.data[CNT_W-1:0];
            pos_row   = 0;
            pos_col   = 0;
          end
          REG_WVERT:  sh_fv = cfg_bus.data[WF_W-1:0];
          REG_WHORZ:  sh_fh = cfg_bus.data[WF_W-1:0];
          REG_SHARPK: sh_k  = cfg_bus.data[K_W-1:0];
          default: ;
        endcase
      end
      if (in_bus.valid && in_bus.ready) begin
        if (sharpen_step('{pixel: in_bus.pixel, pad: in_bus.is_padding}, want_res))
          sharp_q.push_back(want_res);
      end
      if (out_bus.valid && out_bus.ready) begin
        results_seen++;
        got_res.out_pixel = out_bus.out_pixel;
        got_res.frame_end = out_bus.frame_end;
        if (sharp_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, actual pixel %0d frame_end %0b",
                   $time, got_res.out_pixel, got_res.frame_end);
        end else begin
          want_res = sharp_q.pop_front();
          if (got_res.out_pixel !== want_res.out_pixel) begin
            errors++;
            $display("%0t: out_pixel: expected %0d, actual %0d",
                     $time, want_res.out_pixel, got_res.out_pixel);
          end
          if (got_res.frame_end !== want_res.frame_end) begin
            errors++;
            $display("%0t: frame_end: expected %0b, actual %0b",
                     $time, want_res.frame_end, got_res.frame_end);
          end
        end
      end
    end
  end

  // block until all requests are taken and all results are in, then let it settle
  task automatic wait_idle();
    do @(posedge clk);
    while (pixel_q.size() > 0 || in_bus.valid || sharp_q.size() > 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk);
    while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic set_cfg(input logic [1:0] bm, input logic [CNT_W-1:0] w,
                         input logic [CNT_W-1:0] h, input logic [WF_W-1:0] fv,
                         input logic [WF_W-1:0] fh, input logic [K_W-1:0] k);
    wait_idle();
    cfg_write(REG_BORDER, CFG_W'(bm));
    cfg_write(REG_WIDTH,  CFG_W'(w));
    cfg_write(REG_HEIGHT, CFG_W'(h));
    cfg_write(REG_WVERT,  fv);
    cfg_write(REG_WHORZ,  fh);
    cfg_write(REG_SHARPK, CFG_W'(k));
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel(input int style, input int r, input int c);
    case (style)
      0: return PIX_W'($urandom);
      1: return $urandom_range(1) ? 8'd255 : 8'd0;
      2: return PIX_W'(r * 23 + c * 11 + $urandom_range(15));
      default: return PIX_W'(128 + $urandom_range(7));
    endcase
  endfunction

  // one frame in raster order plus its drain; a cut frame stops after cut pixels, with no drain
  task automatic add_frame(input int w, input int h, input int style, input int cut);
    pix_req_t req;
    int n;
    n = 0;
    repeat ($urandom_range(3) == 0 ? $urandom_range(1, 2) : 0) begin
      req.pixel = PIX_W'($urandom);
      req.pad   = 1'b1;
      pixel_q.push_back(req);
      items_sent++;
    end
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        if (cut > 0 && n >= cut) return;
        req.pixel = pick_pixel(style, r, c);
        req.pad   = 1'b0;
        pixel_q.push_back(req);
        n++;
        items_sent++;
      end
    end
    for (int i = 0; i <= w; i++) begin
      req.pixel = PIX_W'($urandom);
      req.pad   = ($urandom_range(3) != 0);
      pixel_q.push_back(req);
      items_sent++;
    end
  endtask

  initial begin
    int w, h, bm, nf;
    logic [WF_W-1:0] fv, fh;
    logic [K_W-1:0]  k;
    rst_n             = 1'b0;
    cyc               = 0;
    errors            = 0;
    results_seen      = 0;
    items_sent        = 0;
    in_bus.valid      = 1'b0;
    in_bus.pixel      = '0;
    in_bus.is_padding = 1'b0;
    out_bus.ready     = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = '0;
    cfg_bus.data      = '0;
    sh_border = BM_ZERO;
    sh_width  = 11'd512;
    sh_height = 11'd512;
    sh_fv     = 17'd39749;
    sh_fh     = 17'd39749;
    sh_k      = 16'd52429;
    pos_row   = 0;
    pos_col   = 0;
    foreach (win[i, j]) win[i][j] = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: each border mode on tiny frames, strength and weight extremes
    set_cfg(BM_ZERO, 11'd3, 11'd3, 17'd39749, 17'd39749, 16'd0);
    add_frame(3, 3, 1, 0);
    set_cfg(BM_MIRROR, 11'd2, 11'd2, 17'd65536, 17'd0, 16'd65535);
    add_frame(2, 2, 0, 0);
    set_cfg(BM_RENORM, 11'd2, 11'd3, 17'd131071, 17'd131071, 16'd52429);
    add_frame(2, 3, 2, 0);
    // mode 3 falls back to zero padding; one-pixel frame under mirroring
    set_cfg(2'd3, 11'd3, 11'd2, 17'd0, 17'd65536, 16'd32768);
    add_frame(3, 2, 0, 0);
    set_cfg(BM_MIRROR, 11'd1, 11'd1, 17'd39749, 17'd39749, 16'd60000);
    add_frame(1, 1, 0, 0);

    // size saturation: zero width and oversized height, then a cut oversized row
    set_cfg(BM_MIRROR, 11'd0, 11'd2047, 17'd20000, 17'd50000, 16'd40000);
    add_frame(1, LINE_MAX, 2, 0);
    set_cfg(BM_RENORM, 11'd2047, 11'd0, 17'd50000, 17'd20000, 16'd45000);
    add_frame(LINE_MAX, 1, 0, 40);

    // random phases: mostly complete small frames, some cut short
    while (items_sent < 1350) begin
      bm = $urandom_range(3);
      w  = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      h  = $urandom_range(1, 8);
      case ($urandom_range(5))
        0:       fv = 17'd0;
        1:       fv = 17'd65536;
        2:       fv = 17'h1FFFF;
        default: fv = WF_W'($urandom_range(65536));
      endcase
      case ($urandom_range(5))
        0:       fh = 17'd0;
        1:       fh = 17'd65536;
        2:       fh = 17'h1FFFF;
        default: fh = WF_W'($urandom_range(65536));
      endcase
      case ($urandom_range(5))
        0:       k = 16'd0;
        1:       k = 16'hFFFF;
        default: k = K_W'($urandom);
      endcase
      set_cfg(bm[1:0], CNT_W'(w), CNT_W'(h), fv, fh, k);
      nf = $urandom_range(1, 3);
      for (int f = 0; f < nf; f++)
        add_frame(w, h, $urandom_range(3),
                  ($urandom_range(7) == 0) ? $urandom_range(1, w * h) : 0);
    end

    wait_idle();
    if (errors == 0 && sharp_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
